// ===== rtl/tve_pkg.sv =====
// Shared types and constants for the tiny VM execute stage.
package tve_pkg;

  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_ADD   = 8'd1;
  localparam logic [7:0] OP_SUB   = 8'd2;
  localparam logic [7:0] OP_LOADI = 8'd3;
  localparam logic [7:0] OP_LOADA = 8'd4;
  localparam logic [7:0] OP_MOVR  = 8'd5;
  localparam logic [7:0] OP_MOVA  = 8'd6;
  localparam logic [7:0] OP_JGT   = 8'd7;
  localparam logic [7:0] OP_JEQ   = 8'd8;
  localparam logic [7:0] OP_JNE   = 8'd9;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNDEF  = 2'd1;
  localparam logic [1:0] ST_BADREG = 2'd2;

  localparam logic [31:0] MASK_B3 = 32'hFF00_0000;
  localparam logic [31:0] MASK_B2 = 32'h00FF_0000;
  localparam logic [31:0] MASK_B1 = 32'h0000_FF00;
  localparam logic [31:0] MASK_B0 = 32'h0000_00FF;

  typedef struct packed {
    logic signed [31:0] immediate;
    logic [7:0]         third_reg;
    logic [7:0]         second_reg;
    logic [7:0]         first_reg;
    logic [7:0]         opcode;
  } instr_t;

  typedef struct packed {
    logic signed [31:0] write_value;
    logic [3:0]         write_index;
    logic               write_valid;
    logic signed [31:0] pc_value;
    logic               jump_taken;
    logic [1:0]         status;
    logic               halted;
  } result_t;

  // register file write port
  typedef struct packed {
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [31:0] wr_val;
  } wb_t;

  // RAM store word port
  typedef struct packed {
    logic        st_en;
    logic [7:0]  addr;
    logic [31:0] data;
  } store_t;

endpackage

// ===== rtl/tve_regfile.sv =====
// Register file: two write-mirrored arrays, three registered read ports, write-through bypass.
module tve_regfile #(
  parameter int REG_COUNT = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rd_en,
  input  logic [3:0]     rd_idx_a,
  input  logic [3:0]     rd_idx_b,
  input  logic [3:0]     rd_idx_c,
  input  tve_pkg::wb_t   wb,
  output logic [31:0]    rd_a,
  output logic [31:0]    rd_b,
  output logic [31:0]    rd_c,
  output logic [31:0]    pc
);

  logic [31:0]          mem_a [REG_COUNT];
  logic [31:0]          mem_b [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [31:0]          rd_a_r, rd_b_r, rd_c_r, pc_r;
  logic [31:0]          rd_a_nxt, rd_b_nxt, rd_c_nxt;

  always_comb begin
    rd_a_nxt = vld_r[rd_idx_a] ? mem_a[rd_idx_a] : '0;
    rd_b_nxt = vld_r[rd_idx_b] ? mem_a[rd_idx_b] : '0;
    rd_c_nxt = vld_r[rd_idx_c] ? mem_b[rd_idx_c] : '0;
    if (wb.wr_en && wb.wr_idx == rd_idx_a) rd_a_nxt = wb.wr_val;
    if (wb.wr_en && wb.wr_idx == rd_idx_b) rd_b_nxt = wb.wr_val;
    if (wb.wr_en && wb.wr_idx == rd_idx_c) rd_c_nxt = wb.wr_val;
  end

  always_ff @(posedge clk) begin
    if (wb.wr_en) begin
      mem_a[wb.wr_idx] <= wb.wr_val;
      mem_b[wb.wr_idx] <= wb.wr_val;
    end
    if (rd_en) begin
      rd_a_r <= rd_a_nxt;
      rd_b_r <= rd_b_nxt;
      rd_c_r <= rd_c_nxt;
    end
  end

  // entries not yet written read as zero; pc copy kept for the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      pc_r  <= '0;
    end else if (wb.wr_en) begin
      vld_r[wb.wr_idx] <= 1'b1;
      if (wb.wr_idx == 4'd0) pc_r <= wb.wr_val;
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;
  assign rd_c = rd_c_r;
  assign pc   = pc_r;

endmodule

// ===== rtl/tve_data_ram.sv =====
// Byte RAM in four banks by address bits [1:0]; one word load or store per cycle while not busy clearing.
module tve_data_ram #(
  parameter int RAM_BYTES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [7:0]      rd_addr,
  input  tve_pkg::store_t st,
  output logic [31:0]     rd_word,
  output logic            busy
);

  localparam int ROWS = (RAM_BYTES + 3) / 4;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [RW-1:0] clr_cnt_r;
  logic          busy_r;
  logic [7:0]    rdata_r [4];
  logic [1:0]    lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + RW'(1);
      if (clr_cnt_r == RW'(ROWS - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) lo_r <= rd_addr[1:0];
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic [1:0] K = 2'(k);

    logic [7:0]    mem [ROWS];
    logic [1:0]    rd_off, st_off;
    logic [8:0]    rd_a9, st_a9;
    logic [RW-1:0] rd_row, st_row, wr_row;
    logic [7:0]    st_byte, wr_byte;
    logic          wr_en;

    always_comb begin
      rd_off = K - rd_addr[1:0];
      st_off = K - st.addr[1:0];
      rd_a9  = {1'b0, rd_addr} + {7'd0, rd_off};
      st_a9  = {1'b0, st.addr} + {7'd0, st_off};
      rd_row = RW'(rd_a9 >> 2);
      st_row = RW'(st_a9 >> 2);
      // big-endian store: lowest address takes the top byte
      case (st_off)
        2'd0:    st_byte = 8'((st.data & tve_pkg::MASK_B3) >> 24);
        2'd1:    st_byte = 8'((st.data & tve_pkg::MASK_B2) >> 16);
        2'd2:    st_byte = 8'((st.data & tve_pkg::MASK_B1) >> 8);
        default: st_byte = 8'(st.data & tve_pkg::MASK_B0);
      endcase
      wr_en   = busy_r || st.st_en;
      wr_row  = busy_r ? clr_cnt_r : st_row;
      wr_byte = busy_r ? 8'd0 : st_byte;
    end

    always_ff @(posedge clk) begin
      if (wr_en) mem[wr_row] <= wr_byte;
      if (rd_en) begin
        rdata_r[k] <= (st.st_en && st_row == rd_row) ? st_byte : mem[rd_row];
      end
    end
  end

  // little-endian load
  assign rd_word = {rdata_r[lo_r + 2'd3], rdata_r[lo_r + 2'd2],
                    rdata_r[lo_r + 2'd1], rdata_r[lo_r]};
  assign busy    = busy_r;

endmodule

// ===== rtl/tve_alu.sv =====
// Decode, register index checks and execute for one instruction.
module tve_alu #(
  parameter int REG_COUNT = 15
) (
  input  logic              fire,
  input  tve_pkg::instr_t   instr,
  input  logic [31:0]       rd_a,
  input  logic [31:0]       rd_b,
  input  logic [31:0]       rd_c,
  input  logic [31:0]       ram_word,
  input  logic [31:0]       pc,
  output tve_pkg::result_t  res,
  output tve_pkg::wb_t      wb,
  output tve_pkg::store_t   st
);

  logic ra_ok, rb_ok, rc_ok, ok, cond, wv, st_en;
  logic [3:0]  widx;
  logic [31:0] wval;

  assign ra_ok = instr.first_reg  < 8'(REG_COUNT);
  assign rb_ok = instr.second_reg < 8'(REG_COUNT);
  assign rc_ok = instr.third_reg  < 8'(REG_COUNT);

  always_comb begin
    res   = '0;
    ok    = 1'b0;
    cond  = 1'b0;
    wv    = 1'b0;
    st_en = 1'b0;
    widx  = '0;
    wval  = '0;

    unique case (instr.opcode) inside
      tve_pkg::OP_HALT: res.halted = 1'b1;
      tve_pkg::OP_LOADI, tve_pkg::OP_LOADA, tve_pkg::OP_MOVA: ok = ra_ok;
      tve_pkg::OP_MOVR: ok = ra_ok && rb_ok;
      tve_pkg::OP_ADD, tve_pkg::OP_SUB, tve_pkg::OP_JGT, tve_pkg::OP_JEQ,
      tve_pkg::OP_JNE: ok = ra_ok && rb_ok && rc_ok;
      default: res.status = tve_pkg::ST_UNDEF;
    endcase

    if (instr.opcode != tve_pkg::OP_HALT && res.status != tve_pkg::ST_UNDEF && !ok) begin
      res.status = tve_pkg::ST_BADREG;
    end

    if (ok) begin
      unique case (instr.opcode) inside
        tve_pkg::OP_ADD: begin
          wv = 1'b1; widx = instr.third_reg[3:0]; wval = rd_a + rd_b;
        end
        tve_pkg::OP_SUB: begin
          wv = 1'b1; widx = instr.third_reg[3:0]; wval = rd_a - rd_b;
        end
        tve_pkg::OP_LOADI: begin
          wv = 1'b1; widx = instr.first_reg[3:0]; wval = instr.immediate;
        end
        tve_pkg::OP_LOADA: begin
          wv = 1'b1; widx = instr.first_reg[3:0]; wval = ram_word;
        end
        tve_pkg::OP_MOVR: begin
          wv = 1'b1; widx = instr.second_reg[3:0]; wval = rd_a;
        end
        tve_pkg::OP_MOVA: st_en = 1'b1;
        tve_pkg::OP_JGT, tve_pkg::OP_JEQ, tve_pkg::OP_JNE: begin
          if (instr.opcode == tve_pkg::OP_JGT)      cond = $signed(rd_b) > $signed(rd_c);
          else if (instr.opcode == tve_pkg::OP_JEQ) cond = rd_b == rd_c;
          else                                      cond = rd_b != rd_c;
          if (cond) begin
            wv = 1'b1; widx = 4'd0; wval = rd_a;
          end
        end
        default: ;
      endcase
    end

    res.jump_taken  = cond;
    res.write_valid = wv;
    res.write_index = widx;
    res.write_value = wval;
    res.pc_value    = (wv && widx == 4'd0) ? wval : pc;
  end

  assign wb.wr_en  = fire && wv;
  assign wb.wr_idx = widx;
  assign wb.wr_val = wval;
  assign st.st_en  = fire && st_en;
  assign st.addr   = instr.second_reg;
  assign st.data   = rd_a;

endmodule

// ===== rtl/tiny_vm_execute_stage.sv =====
// Top level of the tiny VM execute stage.
// Executes one decoded instruction per input beat and returns one result beat per
// instruction. Sustained rate is one instruction per cycle while out_tready is high. At
// input acceptance the operands are read from the register file and from the four
// byte-banked RAM banks (with write-through bypass of the instruction retiring in the
// same cycle) into registers, then executed into the output register.
// After reset the RAM is zeroed by a clearing pass over all ceil(RAM_BYTES/4) rows
// (256 rows at the default size); in_tready stays low until it ends.
module tiny_vm_execute_stage #(
  parameter int RAM_BYTES = 1024,
  parameter int REG_COUNT = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode, first_reg, second_reg, third_reg, immediate
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // halted, status, jump_taken, pc_value, write_valid, write_index, write_value, pad
  output logic [79:0] out_tdata
);

  tve_pkg::instr_t  in_instr, s1_instr_r;
  tve_pkg::result_t res, out_r;
  tve_pkg::wb_t     wb;
  tve_pkg::store_t  st;

  logic        s1_valid_r, out_valid_r, s1_fire, accept, busy;
  logic [3:0]  idx_a, idx_b, idx_c;
  logic [31:0] rd_a, rd_b, rd_c, ram_word, pc;

  assign in_instr  = tve_pkg::instr_t'(in_tdata);
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !busy && (!s1_valid_r || s1_fire);
  assign accept    = in_tvalid && in_tready;

  // out-of-range indices read entry 0; an instruction that uses such an index reports a bad register anyway
  assign idx_a = (in_instr.first_reg  < 8'(REG_COUNT)) ? in_instr.first_reg[3:0]  : 4'd0;
  assign idx_b = (in_instr.second_reg < 8'(REG_COUNT)) ? in_instr.second_reg[3:0] : 4'd0;
  assign idx_c = (in_instr.third_reg  < 8'(REG_COUNT)) ? in_instr.third_reg[3:0]  : 4'd0;

  tve_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_idx_a (idx_a),
    .rd_idx_b (idx_b),
    .rd_idx_c (idx_c),
    .wb       (wb),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .rd_c     (rd_c),
    .pc       (pc)
  );

  tve_data_ram #(.RAM_BYTES(RAM_BYTES)) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_instr.second_reg),
    .st      (st),
    .rd_word (ram_word),
    .busy    (busy)
  );

  tve_alu #(.REG_COUNT(REG_COUNT)) u_alu (
    .fire     (s1_fire),
    .instr    (s1_instr_r),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .rd_c     (rd_c),
    .ram_word (ram_word),
    .pc       (pc),
    .res      (res),
    .wb       (wb),
    .st       (st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept)       s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;
      if (s1_fire)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)  s1_instr_r <= in_instr;
    if (s1_fire) out_r      <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r};

  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !s1_valid_r && !out_valid_r)
    else $error("beat in flight during RAM clear");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.write_valid |-> out_r.status == tve_pkg::ST_OK && !out_r.halted)
    else $error("register write on a failed instruction");

  a_jump_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.jump_taken |->
      out_r.write_valid && out_r.write_index == 4'd0 && out_r.pc_value == out_r.write_value)
    else $error("taken jump did not load pc");

  a_pc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_r.pc_value == pc)
    else $error("result pc differs from register 0");

endmodule

// ===== test/tve_exec_checker.sv =====
// Checker for the tiny VM execute stage: predicts each retired instruction and compares.
`timescale 1ns / 100ps

module tve_exec_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  output int          mismatch_cnt,
  output int          in_flight
);

  localparam int RAM_BYTES = 1024;
  localparam int REG_COUNT = 15;

  logic [31:0]       gpr [REG_COUNT];
  logic [7:0]        mem [RAM_BYTES];
  tve_pkg::result_t  retired_q [$];
  int                out_beats;

  initial begin
    mismatch_cnt = 0;
    in_flight    = 0;
    out_beats    = 0;
  end

  function automatic int ram_at(input logic [7:0] base, input int offs);
    return (int'(base) + offs) % RAM_BYTES;
  endfunction

  // executes one instruction against the shadow register file and RAM
  function automatic tve_pkg::result_t retire_instr(input tve_pkg::instr_t it);
    tve_pkg::result_t r;
    logic             ok;
    logic             cond;
    logic [31:0]      v;
    logic [31:0]      x;
    logic [31:0]      y;
    logic [3:0]       widx;
    logic [31:0]      wval;
    r    = '0;
    ok   = 1'b0;
    cond = 1'b0;
    widx = '0;
    wval = '0;
    if (it.opcode > tve_pkg::OP_JNE) begin
      r.status = tve_pkg::ST_UNDEF;
    end else if (it.opcode == tve_pkg::OP_HALT) begin
      r.halted = 1'b1;
    end else begin
      case (it.opcode)
        tve_pkg::OP_LOADI, tve_pkg::OP_LOADA, tve_pkg::OP_MOVA:
          ok = it.first_reg < REG_COUNT;
        tve_pkg::OP_MOVR: ok = it.first_reg < REG_COUNT && it.second_reg < REG_COUNT;
        default: ok = it.first_reg < REG_COUNT && it.second_reg < REG_COUNT &&
                      it.third_reg < REG_COUNT;
      endcase
      if (!ok) begin
        r.status = tve_pkg::ST_BADREG;
      end else begin
        case (it.opcode)
          tve_pkg::OP_ADD: begin
            r.write_valid = 1'b1;
            widx = it.third_reg[3:0];
            wval = gpr[it.first_reg] + gpr[it.second_reg];
          end
          tve_pkg::OP_SUB: begin
            r.write_valid = 1'b1;
            widx = it.third_reg[3:0];
            wval = gpr[it.first_reg] - gpr[it.second_reg];
          end
          tve_pkg::OP_LOADI: begin
            r.write_valid = 1'b1;
            widx = it.first_reg[3:0];
            wval = it.immediate;
          end
          tve_pkg::OP_LOADA: begin
            // little-endian word
            r.write_valid = 1'b1;
            widx = it.first_reg[3:0];
            wval = {mem[ram_at(it.second_reg, 3)], mem[ram_at(it.second_reg, 2)],
                    mem[ram_at(it.second_reg, 1)], mem[ram_at(it.second_reg, 0)]};
          end
          tve_pkg::OP_MOVR: begin
            r.write_valid = 1'b1;
            widx = it.second_reg[3:0];
            wval = gpr[it.first_reg];
          end
          tve_pkg::OP_MOVA: begin
            // big-endian word, no register write
            v = gpr[it.first_reg];
            mem[ram_at(it.second_reg, 0)] = v[31:24];
            mem[ram_at(it.second_reg, 1)] = v[23:16];
            mem[ram_at(it.second_reg, 2)] = v[15:8];
            mem[ram_at(it.second_reg, 3)] = v[7:0];
          end
          default: begin
            x = gpr[it.second_reg];
            y = gpr[it.third_reg];
            if (it.opcode == tve_pkg::OP_JGT) cond = $signed(x) > $signed(y);
            else if (it.opcode == tve_pkg::OP_JEQ) cond = x == y;
            else cond = x != y;
            if (cond) begin
              r.jump_taken  = 1'b1;
              r.write_valid = 1'b1;
              widx = 4'd0;
              wval = gpr[it.first_reg];
            end
          end
        endcase
        if (r.write_valid) gpr[widx] = wval;
        r.write_index = widx;
        r.write_value = wval;
      end
    end
    r.pc_value = gpr[0];
    return r;
  endfunction

  always @(posedge clk) begin
    tve_pkg::result_t got;
    tve_pkg::result_t want;
    logic             bad;
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
      for (int i = 0; i < RAM_BYTES; i++) mem[i] = '0;
      retired_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = tve_pkg::result_t'(out_tdata[72:0]);
        if (retired_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result beat %0d with no instruction pending", $time, out_beats);
        end else begin
          want = retired_q.pop_front();
          bad = got.halted !== want.halted || got.status !== want.status ||
                got.jump_taken !== want.jump_taken || got.pc_value !== want.pc_value ||
                got.write_valid !== want.write_valid ||
                got.write_index !== want.write_index ||
                got.write_value !== want.write_value;
          if (bad) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $write("%0t: beat %0d exp/got halted %b/%b st %0d/%0d jump %b/%b ",
                     $time, out_beats, want.halted, got.halted, want.status,
                     got.status, want.jump_taken, got.jump_taken);
              $display("pc %h/%h wr %b/%b idx %0d/%0d val %h/%h",
                       want.pc_value, got.pc_value, want.write_valid, got.write_valid,
                       want.write_index, got.write_index, want.write_value,
                       got.write_value);
            end
          end
        end
        out_beats++;
      end
      if (in_tvalid && in_tready)
        retired_q.push_back(retire_instr(tve_pkg::instr_t'(in_tdata)));
    end
    in_flight <= retired_q.size();
  end

endmodule

// ===== test/tb_tiny_vm_execute_stage.sv =====
// Testbench top for the tiny VM execute stage: clock, reset, instruction stream, verdict.
`timescale 1ns / 100ps

module tb_tiny_vm_execute_stage;

  localparam int          LAST_REG       = 14;
  localparam int          BEATS_PER_PASS = 338;
  localparam logic [7:0]  OP_FIRST_UNDEF = tve_pkg::OP_JNE + 8'd1;
  localparam logic [31:0] MAX_POS        = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_NEG        = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  int mismatch_cnt;
  int in_flight;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tiny_vm_execute_stage i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  tve_exec_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatch_cnt(mismatch_cnt),
    .in_flight   (in_flight)
  );

  always @(posedge clk) out_tready <= $urandom_range(99) >= recv_stall_pct;

  function automatic tve_pkg::instr_t mk(input logic [7:0] op, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c,
                                         input logic [31:0] imm);
    tve_pkg::instr_t it;
    it.opcode     = op;
    it.first_reg  = a;
    it.second_reg = b;
    it.third_reg  = c;
    it.immediate  = imm;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return 32'($urandom_range(16)) - 32'd8;
      1: begin
        case ($urandom_range(3))
          0: return MAX_POS;
          1: return MIN_NEG;
          2: return '0;
          default: return ALL_ONES;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed programs, RAM addresses often in a small window, plus bad indexes and noise
  function automatic tve_pkg::instr_t rand_instr();
    tve_pkg::instr_t it;
    int              pick;
    pick = $urandom_range(99);
    it.opcode     = 8'($urandom_range(tve_pkg::OP_JNE, tve_pkg::OP_ADD));
    it.first_reg  = 8'($urandom_range(LAST_REG));
    it.second_reg = 8'($urandom_range(LAST_REG));
    it.third_reg  = 8'($urandom_range(LAST_REG));
    it.immediate  = rand_word();
    if (it.opcode == tve_pkg::OP_LOADA || it.opcode == tve_pkg::OP_MOVA)
      it.second_reg = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    if (it.opcode >= tve_pkg::OP_JGT && $urandom_range(2) == 0)
      it.third_reg = it.second_reg;
    if (pick < 3) begin
      it.opcode = tve_pkg::OP_HALT;
    end else if (pick < 85) begin
      // well-formed as built
    end else if (pick < 93) begin
      case ($urandom_range(2))
        0: it.first_reg = 8'($urandom_range(255, LAST_REG + 1));
        1: it.second_reg = 8'($urandom_range(255, LAST_REG + 1));
        default: it.third_reg = 8'($urandom_range(255, LAST_REG + 1));
      endcase
    end else if (pick < 96) begin
      it.opcode = 8'($urandom_range(255, OP_FIRST_UNDEF));
    end else begin
      it.opcode     = 8'($urandom_range(255));
      it.first_reg  = 8'($urandom);
      it.second_reg = 8'($urandom);
      it.third_reg  = 8'($urandom);
      it.immediate  = $urandom;
    end
    return it;
  endfunction

  task automatic issue(input tve_pkg::instr_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int idle_by_pass [4];
    int stall_by_pass [4];
    idle_by_pass  = '{0, 65, 0, 20};
    stall_by_pass = '{0, 0, 65, 20};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every opcode, each special case
    issue(mk(tve_pkg::OP_LOADI, 8'd1, 8'd0, 8'd0, MAX_POS));
    issue(mk(tve_pkg::OP_LOADI, 8'd2, 8'd255, 8'd255, MIN_NEG));
    issue(mk(tve_pkg::OP_LOADI, 8'd14, 8'd0, 8'd0, ALL_ONES));
    issue(mk(tve_pkg::OP_ADD, 8'd1, 8'd14, 8'd4, '0));        // wraps to max - 1
    issue(mk(tve_pkg::OP_ADD, 8'd1, 8'd1, 8'd5, '0));         // signed overflow
    issue(mk(tve_pkg::OP_SUB, 8'd2, 8'd1, 8'd6, '0));
    issue(mk(tve_pkg::OP_MOVR, 8'd14, 8'd3, 8'd0, '0));
    issue(mk(tve_pkg::OP_MOVA, 8'd1, 8'd255, 8'd0, '0));      // top of the byte address range
    issue(mk(tve_pkg::OP_LOADA, 8'd7, 8'd255, 8'd0, '0));     // big-endian in, little-endian out
    issue(mk(tve_pkg::OP_LOADI, 8'd8, 8'd0, 8'd0, 32'h1234_5678));
    issue(mk(tve_pkg::OP_MOVA, 8'd8, 8'd0, 8'd0, '0));
    issue(mk(tve_pkg::OP_LOADA, 8'd9, 8'd1, 8'd0, '0));       // unaligned overlap
    issue(mk(tve_pkg::OP_JGT, 8'd8, 8'd1, 8'd2, '0));         // signed compare, taken
    issue(mk(tve_pkg::OP_JGT, 8'd9, 8'd2, 8'd1, '0));
    issue(mk(tve_pkg::OP_JEQ, 8'd1, 8'd3, 8'd14, '0));
    issue(mk(tve_pkg::OP_JEQ, 8'd9, 8'd1, 8'd2, '0));
    issue(mk(tve_pkg::OP_JNE, 8'd9, 8'd1, 8'd2, '0));
    issue(mk(tve_pkg::OP_JNE, 8'd8, 8'd3, 8'd3, '0));
    issue(mk(tve_pkg::OP_HALT, 8'd255, 8'd255, 8'd255, ALL_ONES));
    issue(mk(OP_FIRST_UNDEF, 8'd1, 8'd2, 8'd3, '0));
    issue(mk(8'd255, 8'd0, 8'd0, 8'd0, '0));
    issue(mk(tve_pkg::OP_ADD, 8'd1, 8'd2, 8'd15, '0));        // bad destination index
    issue(mk(tve_pkg::OP_LOADI, 8'd255, 8'd0, 8'd0, MAX_POS));
    issue(mk(tve_pkg::OP_MOVR, 8'd1, 8'd15, 8'd255, '0));
    issue(mk(tve_pkg::OP_MOVA, 8'd15, 8'd4, 8'd0, '0));
    issue(mk(tve_pkg::OP_LOADA, 8'd3, 8'd200, 8'd255, '0));   // unchecked third index
    issue(mk(tve_pkg::OP_LOADI, 8'd0, 8'd0, 8'd0, 32'hDEAD_BEEF)); // direct pc write

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_by_pass[p];
      recv_stall_pct  = stall_by_pass[p];
      repeat (BEATS_PER_PASS) issue(rand_instr());
    end
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (in_flight != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tve_pkg.sv
rtl/tve_regfile.sv
rtl/tve_data_ram.sv
rtl/tve_alu.sv
rtl/tiny_vm_execute_stage.sv
test/tve_exec_checker.sv
test/tb_tiny_vm_execute_stage.sv
